/* src/nfc_response_frame_parser_top_defines.svh */
// Assertion macros used by the parser module.
`ifndef NFC_RESPONSE_FRAME_PARSER_TOP_DEFINES_SVH
`define NFC_RESPONSE_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NRFP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NRFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/nrfp_pkg.sv */
package nrfp_pkg;

   // Fixed bytes of the response frame.
   localparam logic [7:0] TFI_IN     = 8'hD5;
   localparam logic [7:0] START_HI   = 8'hFF;
   localparam logic [7:0] STATUS_RDY = 8'h01;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;

   // Configuration register index width and reset values.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [7:0] EXPECTED_COMMAND_RST = 8'h00;
   localparam logic [7:0] PAYLOAD_LIMIT_RST    = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXPECTED_COMMAND = 1'b0,
      CSR_PAYLOAD_LIMIT    = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_PRE  = 4'd1,
      PH_SC0  = 4'd2,
      PH_SC1  = 4'd3,
      PH_LEN  = 4'd4,
      PH_LCS  = 4'd5,
      PH_TFI  = 4'd6,
      PH_RSP  = 4'd7,
      PH_DATA = 4'd8,
      PH_DCS  = 4'd9,
      PH_POST = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_NOT_READY  = 3'd1,
      ERR_START_CODE = 3'd2,
      ERR_LCS        = 3'd3,
      ERR_TFI        = 3'd4,
      ERR_RSP_CODE   = 3'd5,
      ERR_DCS        = 3'd6,
      ERR_POSTAMBLE  = 3'd7
   } err_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_word_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       frame_done;
      logic       frame_ok;
      err_type    error_code;
      logic [7:0] payload_count;
   } rsp_word_type;

   // Held word passed from the input register to the parser.
   typedef struct packed {
      logic         valid;
      req_word_type word;
   } held_type;

   typedef struct packed {
      logic [7:0] expected_command;
      logic [7:0] payload_limit;
   } cfg_type;

endpackage

/* src/nrfp_req_if.sv */
interface nrfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

/* src/nrfp_rsp_if.sv */
interface nrfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       payload_valid;
   logic       frame_done;
   logic       frame_ok;
   logic [2:0] error_code;
   logic [7:0] payload_count;

   modport source (output valid, output payload_byte, output payload_valid,
                   output frame_done, output frame_ok, output error_code,
                   output payload_count, input ready);
   modport sink   (input valid, input payload_byte, input payload_valid,
                   input frame_done, input frame_ok, input error_code,
                   input payload_count, output ready);
endinterface

/* src/nrfp_csr.sv */
module nrfp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [nrfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata,
   output nrfp_pkg::cfg_type                cfg
);
   import nrfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index on a write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_EXPECTED_COMMAND: cfg_in.expected_command = csr_wdata;
            CSR_PAYLOAD_LIMIT:    cfg_in.payload_limit    = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command <= EXPECTED_COMMAND_RST;
         cfg_ff.payload_limit    <= PAYLOAD_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

/* src/nrfp_in_stage.sv */
module nrfp_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  nrfp_pkg::req_word_type in_word,
   output logic                   in_ready,
   input  logic                   advance,
   output nrfp_pkg::held_type     held
);
   import nrfp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   req_word_type word_in;

   // The register takes a new word when it is empty or its word moves on.
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      word_in  = (in_valid && in_ready) ? in_word : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign held.valid = valid_ff;
   assign held.word  = word_ff;
endmodule

/* src/nrfp_parse.sv */
`include "nfc_response_frame_parser_top_defines.svh"

module nrfp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  nrfp_pkg::held_type     held,
   input  nrfp_pkg::cfg_type      cfg,
   output logic                   advance,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output nrfp_pkg::rsp_word_type rsp_word
);
   import nrfp_pkg::*;

   phase_type    phase_ff, phase_in;
   logic [7:0]   len_ff, len_in;
   logic [7:0]   rem_ff, rem_in;
   logic [7:0]   sum_ff, sum_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   rsp_word_type res_c;
   logic         fire;
   logic [7:0]   b;

   // The held word moves on whenever the result register is free.
   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = held.valid && advance;
   assign b       = held.word.rx_byte;

   // Frame state machine and result for one received byte.
   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      res_c    = '0;
      if (fire) begin
         if (held.word.frame_start) begin
            len_in = 8'd0;
            rem_in = 8'd0;
            sum_in = 8'd0;
            cnt_in = 8'd0;
            if (b == STATUS_RDY) begin
               phase_in = PH_PRE;
            end else begin
               res_c.frame_done = 1'b1;
               res_c.error_code = ERR_NOT_READY;
            end
         end else begin
            unique case (phase_ff)
               PH_PRE: begin
                  if (b == ZERO_BYTE) phase_in = PH_SC0;
                  else begin
                     res_c.frame_done = 1'b1;
                     res_c.error_code = ERR_START_CODE;
                  end
               end
               PH_SC0: begin
                  if (b == ZERO_BYTE) phase_in = PH_SC1;
                  else begin
                     res_c.frame_done = 1'b1;
                     res_c.error_code = ERR_START_CODE;
                  end
               end
               PH_SC1: begin
                  if (b == START_HI) phase_in = PH_LEN;
                  else begin
                     res_c.frame_done = 1'b1;
                     res_c.error_code = ERR_START_CODE;
                  end
               end
               PH_LEN: begin
                  len_in   = b;
                  rem_in   = (b >= 8'd2) ? b - 8'd2 : 8'd0;
                  phase_in = PH_LCS;
               end
               PH_LCS: begin
                  if (8'(len_ff + b) == 8'd0) phase_in = PH_TFI;
                  else begin
                     res_c.frame_done = 1'b1;
                     res_c.error_code = ERR_LCS;
                  end
               end
               PH_TFI: begin
                  if (b == TFI_IN) begin
                     sum_in   = b;
                     phase_in = PH_RSP;
                  end else begin
                     res_c.frame_done = 1'b1;
                     res_c.error_code = ERR_TFI;
                  end
               end
               PH_RSP: begin
                  if (b == 8'(cfg.expected_command + 8'd1)) begin
                     sum_in   = 8'(sum_ff + b);
                     phase_in = (rem_ff != 8'd0) ? PH_DATA : PH_DCS;
                  end else begin
                     res_c.frame_done = 1'b1;
                     res_c.error_code = ERR_RSP_CODE;
                  end
               end
               PH_DATA: begin
                  sum_in = 8'(sum_ff + b);
                  if (cnt_ff < cfg.payload_limit) begin
                     res_c.payload_valid = 1'b1;
                     res_c.payload_byte  = b;
                     cnt_in              = 8'(cnt_ff + 8'd1);
                  end
                  rem_in = 8'(rem_ff - 8'd1);
                  if (rem_in == 8'd0) phase_in = PH_DCS;
               end
               PH_DCS: begin
                  if (8'(sum_ff + b) == 8'd0) phase_in = PH_POST;
                  else begin
                     res_c.frame_done = 1'b1;
                     res_c.error_code = ERR_DCS;
                  end
               end
               PH_POST: begin
                  res_c.frame_done = 1'b1;
                  if (b == ZERO_BYTE) res_c.frame_ok = 1'b1;
                  else res_c.error_code = ERR_POSTAMBLE;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
         if (res_c.frame_done) phase_in = PH_IDLE;
      end
      res_c.payload_count = cnt_in;
   end

   // Result register: loaded on each processed word, emptied when taken.
   always_comb begin
      rsp_word_in  = fire ? res_c : rsp_word_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         len_ff       <= 8'd0;
         rem_ff       <= 8'd0;
         sum_ff       <= 8'd0;
         cnt_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         rem_ff       <= rem_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks on the parser's own bookkeeping.
   `NRFP_ASSERT_IMPL(a_ok_clean, clock, reset, rsp_valid_ff && rsp_word_ff.frame_ok, rsp_word_ff.frame_done && (rsp_word_ff.error_code == ERR_NONE), "frame_ok without a clean frame end")
   `NRFP_ASSERT_IMPL(a_err_ends, clock, reset, rsp_valid_ff && (rsp_word_ff.error_code != ERR_NONE), rsp_word_ff.frame_done && !rsp_word_ff.frame_ok, "error code without a failed frame end")
   `NRFP_ASSERT_IMPL(a_data_left, clock, reset, phase_ff == PH_DATA, rem_ff != 8'd0, "payload phase with nothing left to receive")
   `NRFP_ASSERT_NEXT(a_done_idle, clock, reset, fire && res_c.frame_done, phase_ff == PH_IDLE, "parser not idle after a frame end")
   `NRFP_ASSERT_IMPL(a_limit, clock, reset, fire && res_c.payload_valid, cnt_in <= cfg.payload_limit, "payload delivered beyond the limit")
endmodule

/* src/nfc_response_frame_parser_top.sv */
// Response frame parser.
// The req_ch channel carries one received byte per word, with frame_start
// set on the ready-status byte that opens a response. The rsp_ch channel
// returns exactly one result word for every request word: payload bytes as
// they stream past (flagged valid up to payload_limit), and on the last byte
// of a frame, or on the first failed check, frame_done with frame_ok or an
// error code. Both channels use a valid/ready handshake.
// The csr_ port writes expected_command (index 0) and payload_limit (index 1);
// write it only while no word is in flight.
// The result word passes through one input register, then the byte check and
// state update into the result register. Throughput is one word per cycle
// while the receiver keeps taking results, set by the single parser state
// update.
// When the receiver stalls, the result register holds its word and req_ch.ready
// falls once the input register also holds a word.
// Reset clears the parser to idle, empties both registers and restores
// expected_command to 0 and payload_limit to 255.
module nfc_response_frame_parser_top (
   input  logic                             clock,
   input  logic                             reset,
   nrfp_req_if.sink                         req_ch,
   nrfp_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [nrfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);
   import nrfp_pkg::*;

   cfg_type      cfg;
   held_type     held;
   req_word_type in_word;
   rsp_word_type rsp_word;
   logic         advance;

   assign in_word.rx_byte     = req_ch.rx_byte;
   assign in_word.frame_start = req_ch.frame_start;

   nrfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nrfp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_word  (in_word),
      .in_ready (req_ch.ready),
      .advance  (advance),
      .held     (held)
   );

   nrfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .held      (held),
      .cfg       (cfg),
      .advance   (advance),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_word  (rsp_word)
   );

   // Spread the result word over the channel's fields.
   assign rsp_ch.payload_byte  = rsp_word.payload_byte;
   assign rsp_ch.payload_valid = rsp_word.payload_valid;
   assign rsp_ch.frame_done    = rsp_word.frame_done;
   assign rsp_ch.frame_ok      = rsp_word.frame_ok;
   assign rsp_ch.error_code    = rsp_word.error_code;
   assign rsp_ch.payload_count = rsp_word.payload_count;
endmodule
